@@ rtl/sts_pkg.sv @@
// sts_pkg: shared types, token and mode codes and keyword table for the sql token scanner
// used by every file under rtl; depends on nothing
`default_nettype none

package sts_pkg;

    localparam int MAX_SOURCE_LEN = 65535;
    localparam logic [15:0] POS_CAP =
        (MAX_SOURCE_LEN < 65535) ? 16'(MAX_SOURCE_LEN) : 16'hFFFF;

    // results one request can cause, and the result queue behind the scanner
    localparam int MAX_RES    = 3;
    localparam int CNT_W      = $clog2(MAX_RES + 1);
    localparam int SLOT_W     = $clog2(MAX_RES);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // scanner modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_STR   = 3'd1;
    localparam logic [2:0] M_NUM   = 3'd2;
    localparam logic [2:0] M_IDENT = 3'd3;
    localparam logic [2:0] M_BANG  = 3'd4;
    localparam logic [2:0] M_LT    = 3'd5;
    localparam logic [2:0] M_GT    = 3'd6;

    // token types
    localparam logic [5:0] T_STRING  = 6'd0;
    localparam logic [5:0] T_NUMBER  = 6'd1;
    localparam logic [5:0] T_IDENT   = 6'd2;
    localparam logic [5:0] T_KW0     = 6'd3;
    localparam logic [5:0] T_NE      = 6'd28;
    localparam logic [5:0] T_LE      = 6'd29;
    localparam logic [5:0] T_GE      = 6'd30;
    localparam logic [5:0] T_EQ      = 6'd31;
    localparam logic [5:0] T_LT      = 6'd32;
    localparam logic [5:0] T_GT      = 6'd33;
    localparam logic [5:0] T_PLUS    = 6'd34;
    localparam logic [5:0] T_MINUS   = 6'd35;
    localparam logic [5:0] T_STAR    = 6'd36;
    localparam logic [5:0] T_SLASH   = 6'd37;
    localparam logic [5:0] T_DOT     = 6'd38;
    localparam logic [5:0] T_COMMA   = 6'd39;
    localparam logic [5:0] T_LPAREN  = 6'd40;
    localparam logic [5:0] T_RPAREN  = 6'd41;
    localparam logic [5:0] T_SEMI    = 6'd42;
    localparam logic [5:0] T_INVALID = 6'd43;
    localparam logic [5:0] T_END     = 6'd44;

    // result kinds
    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam int NUM_KW = 25;

    // upper-case keyword text, packed right-aligned, in token type order
    localparam logic [47:0] KW_CODE [NUM_KW] = '{
        48'h53454C454354, // SELECT
        48'h000046524F4D, // FROM
        48'h00004A4F494E, // JOIN
        48'h00494E4E4552, // INNER
        48'h000000004F4E, // ON
        48'h005748455245, // WHERE
        48'h0047524F5550, // GROUP
        48'h000000004259, // BY
        48'h484156494E47, // HAVING
        48'h00000053554D, // SUM
        48'h00434F554E54, // COUNT
        48'h000000415647, // AVG
        48'h0000004D494E, // MIN
        48'h0000004D4158, // MAX
        48'h000000004153, // AS
        48'h000000414E44, // AND
        48'h000000004F52, // OR
        48'h435245415445, // CREATE
        48'h005441424C45, // TABLE
        48'h494E53455254, // INSERT
        48'h0000494E544F, // INTO
        48'h56414C554553, // VALUES
        48'h555044415445, // UPDATE
        48'h000000534554, // SET
        48'h44454C455445  // DELETE
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] source_byte;
    } sts_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic [5:0]  token_type;
        logic [15:0] token_pos;
        logic [15:0] text_len;
        logic        last_of_item;
    } sts_out_t;

    // results of one request, slot 0 first
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        sts_out_t [MAX_RES-1:0]     slot;
    } sts_push_t;

    function automatic logic [5:0] kw_type(logic [47:0] kbuf, logic [15:0] len);
        logic [5:0] t;
        t = T_IDENT;
        if (len != 16'd0 && len <= 16'd6) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (KW_CODE[k] == kbuf) begin
                    t = T_KW0 + 6'(k);
                end
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sql_token_scanner.sv @@
// sql_token_scanner: streaming sql lexer, one source byte or end-of-source per request
// depends on sts_pkg, sts_lexer_core and sts_result_fifo
//
// src channel: src_item.cmd = 0 carries one query byte, cmd = 1 ends the source.
// tok channel: token text bytes (kind 0) and token records (kind 1), one per request;
//   last_of_item marks the final result caused by a source request.
// a source request lands in an input register, is lexed there and, once the queue has
//   room, its results (none to three) are written to an eight-entry result queue; the
//   first result shows on the token port once it is in the queue.
// throughput: one source request per cycle while each yields at most one result on
//   average and tok_stall stays low; the token port drains one result per cycle while
//   tok_stall is low, so a request with two or three results takes that many reads.
// when tok_stall holds the queue, src_stall rises once more than five results wait
//   and a request sits in the input register; nothing is dropped.
// reset clears the scanner to idle between tokens with position zero and empties the
//   queue. an end-of-source request closes any open token, emits END and returns the
//   scanner to that same state, so a new query may follow at once.
`default_nettype none

module sql_token_scanner (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  sts_pkg::sts_in_t  src_item,
    output logic              tok_valid,
    input  logic              tok_stall,
    output sts_pkg::sts_out_t tok_item
);
    import sts_pkg::*;

    sts_push_t push;
    logic      room;

    sts_lexer_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .room      (room),
        .push      (push)
    );

    sts_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

`default_nettype wire

@@ rtl/sts_lexer_core.sv @@
// sts_lexer_core: input register, scanner state and the per-byte lexing step
// depends on sts_pkg; feeds up to three results per request to sts_result_fifo
`default_nettype none

module sts_lexer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  sts_pkg::sts_in_t   src_item,
    input  logic               room,
    output sts_pkg::sts_push_t push
);
    import sts_pkg::*;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'h20 : c;
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic logic [5:0] single_type(logic [7:0] c);
        logic [5:0] t;
        case (c)
            CH_EQ:     t = T_EQ;
            CH_PLUS:   t = T_PLUS;
            CH_MINUS:  t = T_MINUS;
            CH_STAR:   t = T_STAR;
            CH_SLASH:  t = T_SLASH;
            CH_DOT:    t = T_DOT;
            CH_COMMA:  t = T_COMMA;
            CH_LPAREN: t = T_LPAREN;
            CH_RPAREN: t = T_RPAREN;
            CH_SEMI:   t = T_SEMI;
            default:   t = T_INVALID;
        endcase
        return t;
    endfunction

    function automatic sts_out_t rec(logic kind, logic [7:0] c, logic [5:0] t,
                                     logic [15:0] start, logic [15:0] len);
        sts_out_t r;
        r.kind         = kind;
        r.text_byte    = c;
        r.token_type   = t;
        r.token_pos    = start;
        r.text_len     = len;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    // input register
    logic    hold_valid_reg;
    sts_in_t hold_reg;
    logic    advance;

    assign advance   = hold_valid_reg && room;
    assign src_stall = hold_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            hold_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            hold_reg <= src_item;
        end
    end

    // scanner state
    logic [2:0]  mode_reg,  mode_next;
    logic        quote_reg, quote_next;
    logic        esc_reg,   esc_next;
    logic        dot_reg,   dot_next;
    logic [47:0] kw_reg,    kw_next;
    logic [15:0] len_reg,   len_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] pos_reg,   pos_next;

    sts_out_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]       n;
    logic [7:0]             b;
    logic                   do_flush;
    logic                   do_fresh;

    always_comb
    begin
        b          = hold_reg.source_byte;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        dot_next   = dot_reg;
        kw_next    = kw_reg;
        len_next   = len_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        res        = '0;
        n          = '0;
        do_flush   = 1'b0;
        do_fresh   = 1'b0;

        if (hold_reg.cmd)
        begin
            do_flush = 1'b1;
        end
        else
        begin
            case (mode_reg)
                M_STR:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        len_next = sat_inc(len_next);
                        res[n[SLOT_W-1:0]] = rec(KIND_TEXT, b, T_STRING, start_next, len_next);
                        n = n + 1'b1;
                    end
                    else if (b == (quote_reg ? CH_DQUOTE : CH_SQUOTE))
                    begin
                        res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, T_STRING,
                                                 start_next, len_next);
                        n = n + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        len_next = sat_inc(len_next);
                        res[n[SLOT_W-1:0]] = rec(KIND_TEXT, b, T_STRING, start_next, len_next);
                        n = n + 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit(b) || (b == CH_DOT && !dot_reg))
                    begin
                        if (b == CH_DOT)
                        begin
                            dot_next = 1'b1;
                        end
                        len_next = sat_inc(len_next);
                        res[n[SLOT_W-1:0]] = rec(KIND_TEXT, b, T_STRING, start_next, len_next);
                        n = n + 1'b1;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || b == CH_UNDER)
                    begin
                        if (len_reg < 16'd6)
                        begin
                            kw_next = {kw_reg[39:0], to_upper(b)};
                        end
                        len_next = sat_inc(len_next);
                        res[n[SLOT_W-1:0]] = rec(KIND_TEXT, b, T_STRING, start_next, len_next);
                        n = n + 1'b1;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                M_BANG:
                begin
                    if (b == CH_EQ)
                    begin
                        res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, T_NE, start_reg, 16'd2);
                        n = n + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                M_LT:
                begin
                    if (b == CH_GT || b == CH_EQ)
                    begin
                        res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00,
                                                 (b == CH_GT) ? T_NE : T_LE,
                                                 start_reg, 16'd2);
                        n = n + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                M_GT:
                begin
                    if (b == CH_EQ)
                    begin
                        res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, T_GE, start_reg, 16'd2);
                        n = n + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                default:
                begin
                    do_fresh = 1'b1;
                end
            endcase
        end

        // close the open token
        if (do_flush)
        begin
            case (mode_reg)
                M_STR:
                begin
                    // a dangling backslash is kept as text
                    if (esc_reg)
                    begin
                        len_next = sat_inc(len_next);
                        res[n[SLOT_W-1:0]] = rec(KIND_TEXT, CH_BSLASH, T_STRING,
                                                 start_next, len_next);
                        n = n + 1'b1;
                    end
                    res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, T_STRING,
                                             start_next, len_next);
                    n = n + 1'b1;
                end
                M_NUM:
                begin
                    res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, T_NUMBER,
                                             start_next, len_next);
                    n = n + 1'b1;
                end
                M_IDENT:
                begin
                    res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, kw_type(kw_reg, len_reg),
                                             start_next, len_next);
                    n = n + 1'b1;
                end
                M_BANG:
                begin
                    res[n[SLOT_W-1:0]] = rec(KIND_RECORD, CH_BANG, T_INVALID,
                                             start_next, 16'd1);
                    n = n + 1'b1;
                end
                M_LT:
                begin
                    res[n[SLOT_W-1:0]] = rec(KIND_RECORD, CH_LT, T_LT, start_next, 16'd1);
                    n = n + 1'b1;
                end
                M_GT:
                begin
                    res[n[SLOT_W-1:0]] = rec(KIND_RECORD, CH_GT, T_GT, start_next, 16'd1);
                    n = n + 1'b1;
                end
                default:
                begin
                end
            endcase
            mode_next = M_IDLE;
            esc_next  = 1'b0;
        end

        // scan the byte as the first of a new token
        if (do_fresh)
        begin
            mode_next  = M_IDLE;
            start_next = pos_reg;
            len_next   = 16'd0;
            esc_next   = 1'b0;
            if (is_space(b))
            begin
            end
            else if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                mode_next  = M_STR;
                quote_next = (b == CH_DQUOTE);
            end
            else if (is_digit(b))
            begin
                mode_next = M_NUM;
                dot_next  = 1'b0;
                len_next  = 16'd1;
                res[n[SLOT_W-1:0]] = rec(KIND_TEXT, b, T_STRING, start_next, len_next);
                n = n + 1'b1;
            end
            else if (is_alpha(b) || b == CH_UNDER)
            begin
                mode_next = M_IDENT;
                kw_next   = {40'h0, to_upper(b)};
                len_next  = 16'd1;
                res[n[SLOT_W-1:0]] = rec(KIND_TEXT, b, T_STRING, start_next, len_next);
                n = n + 1'b1;
            end
            else if (b == CH_BANG)
            begin
                mode_next = M_BANG;
            end
            else if (b == CH_LT)
            begin
                mode_next = M_LT;
            end
            else if (b == CH_GT)
            begin
                mode_next = M_GT;
            end
            else
            begin
                res[n[SLOT_W-1:0]] = rec(KIND_RECORD, b, single_type(b), start_next, 16'd1);
                n = n + 1'b1;
            end
        end

        if (hold_reg.cmd)
        begin
            res[n[SLOT_W-1:0]] = rec(KIND_RECORD, 8'h00, T_END, pos_reg, 16'd0);
            n = n + 1'b1;
            // end of source: back to reset for the next query
            mode_next  = M_IDLE;
            quote_next = 1'b0;
            esc_next   = 1'b0;
            dot_next   = 1'b0;
            kw_next    = '0;
            len_next   = '0;
            start_next = '0;
            pos_next   = '0;
        end
        else if (pos_reg < POS_CAP)
        begin
            pos_next = pos_reg + 16'd1;
        end

        if (n != '0)
        begin
            res[SLOT_W'(n - 1'b1)].last_of_item = 1'b1;
        end
    end

    assign push.count = advance ? n : '0;
    assign push.slot  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            quote_reg <= 1'b0;
            esc_reg   <= 1'b0;
            dot_reg   <= 1'b0;
            kw_reg    <= '0;
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            dot_reg   <= dot_next;
            kw_reg    <= kw_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sts_result_fifo.sv @@
// sts_result_fifo: eight-entry result queue, up to three writes and one read per cycle
// depends on sts_pkg; filled by sts_lexer_core, drives the token channel
`default_nettype none

module sts_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  sts_pkg::sts_push_t push,
    output logic               room,
    output logic               tok_valid,
    input  logic               tok_stall,
    output sts_pkg::sts_out_t  tok_item
);
    import sts_pkg::*;

    sts_out_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg,  count_next;
    logic                 pop;

    assign tok_valid = (count_reg != '0);
    assign tok_item  = mem[rd_ptr_reg];
    assign pop       = tok_valid && !tok_stall;

    // room for a full burst of results from one request
    assign room = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_RES));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (CNT_W'(i) < push.count)
            begin
                mem[wr_ptr_reg + FIFO_AW'(i)] <= push.slot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sts_checker.sv @@
// sts_checker: port-level checks for sql_token_scanner, attached by bind
// depends on sts_pkg
`default_nettype none

module sts_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    input  logic              src_stall,
    input  sts_pkg::sts_in_t  src_item,
    input  logic              tok_valid,
    input  logic              tok_stall,
    input  sts_pkg::sts_out_t tok_item
);
    import sts_pkg::*;

    // a stalled source request holds
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_item))
        else $error("source request changed while stalled");

    // a stalled result holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
        else $error("result changed while stalled");

    // text bytes carry the STRING type and at least one byte of length
    a_text_form: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.kind == KIND_TEXT |->
            tok_item.token_type == T_STRING && tok_item.text_len != 16'd0)
        else $error("malformed text byte result");

    // END closes the request and carries no text
    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.kind == KIND_RECORD && tok_item.token_type == T_END |->
            tok_item.last_of_item && tok_item.text_len == 16'd0
            && tok_item.text_byte == 8'h00)
        else $error("malformed END record");

    // two-character operators have length two
    a_two_char: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.kind == KIND_RECORD
            && (tok_item.token_type == T_NE || tok_item.token_type == T_LE
                || tok_item.token_type == T_GE) |->
            tok_item.text_len == 16'd2)
        else $error("two-character operator with wrong length");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (.*);

`default_nettype wire

@@ tb/sv/sts_tb_pkg.sv @@
// sts_tb_pkg: request codes and the lexer scoreboard for the sql token scanner bench
// depends on sts_pkg for the port structs, mode codes and token type codes
package sts_tb_pkg;
    import sts_pkg::*;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int REPORT_CAP = 100;

    class lexer_scoreboard;
        string    kw_text [NUM_KW];
        sts_out_t expected_tokens [$];
        int       errors;

        // lexer state as seen from the ports
        logic [2:0]  mode;
        logic        quote_dbl;
        logic        esc_pending;
        logic        dot_seen;
        logic [47:0] kw_buf;
        logic [15:0] tok_len;
        logic [15:0] tok_start;
        logic [15:0] byte_pos;
        sts_out_t    step_out [$];

        function new();
            kw_text = '{"SELECT", "FROM", "JOIN", "INNER", "ON", "WHERE", "GROUP", "BY",
                        "HAVING", "SUM", "COUNT", "AVG", "MIN", "MAX", "AS", "AND", "OR",
                        "CREATE", "TABLE", "INSERT", "INTO", "VALUES", "UPDATE", "SET",
                        "DELETE"};
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode        = M_IDLE;
            quote_dbl   = 1'b0;
            esc_pending = 1'b0;
            dot_seen    = 1'b0;
            kw_buf      = '0;
            tok_len     = '0;
            tok_start   = '0;
            byte_pos    = '0;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_alpha(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit is_word(logic [7:0] b);
            return is_alpha(b) || is_digit(b) || b == "_";
        endfunction

        function bit is_space(logic [7:0] b);
            return b == " " || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function logic [7:0] to_upper(logic [7:0] b);
            return (b >= "a" && b <= "z") ? b - 8'd32 : b;
        endfunction

        function void push_out(logic kind, logic [7:0] b, logic [5:0] t,
                               logic [15:0] st, logic [15:0] len);
            sts_out_t r;
            if (step_out.size() >= MAX_RES)
                return;
            r.kind         = kind;
            r.text_byte    = b;
            r.token_type   = t;
            r.token_pos    = st;
            r.text_len     = len;
            r.last_of_item = 1'b0;
            step_out.push_back(r);
        endfunction

        function void add_text(logic [7:0] b);
            if (tok_len != 16'hFFFF)
                tok_len++;
            push_out(KIND_TEXT, b, T_STRING, tok_start, tok_len);
        endfunction

        function logic [5:0] word_type();
            logic [47:0] code;
            string       s;
            if (tok_len == 16'd0 || tok_len > 16'd6)
                return T_IDENT;
            for (int k = 0; k < NUM_KW; k++)
            begin
                s    = kw_text[k];
                code = '0;
                for (int j = 0; j < s.len(); j++)
                    code = {code[39:0], s[j]};
                if (code == kw_buf)
                    return T_KW0 + 6'(k);
            end
            return T_IDENT;
        endfunction

        function void close_token();
            case (mode)
                M_STR:
                begin
                    // a backslash left open at the end is kept as text
                    if (esc_pending)
                        add_text(CH_BSLASH);
                    push_out(KIND_RECORD, '0, T_STRING, tok_start, tok_len);
                end
                M_NUM:   push_out(KIND_RECORD, '0, T_NUMBER, tok_start, tok_len);
                M_IDENT: push_out(KIND_RECORD, '0, word_type(), tok_start, tok_len);
                M_BANG:  push_out(KIND_RECORD, "!", T_INVALID, tok_start, 16'd1);
                M_LT:    push_out(KIND_RECORD, "<", T_LT, tok_start, 16'd1);
                M_GT:    push_out(KIND_RECORD, ">", T_GT, tok_start, 16'd1);
                default: ;
            endcase
            mode        = M_IDLE;
            esc_pending = 1'b0;
        endfunction

        function void open_token(logic [7:0] b);
            logic [5:0] t;
            mode        = M_IDLE;
            tok_start   = byte_pos;
            tok_len     = '0;
            esc_pending = 1'b0;
            if (is_space(b))
                return;
            if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                mode      = M_STR;
                quote_dbl = (b == CH_DQUOTE);
                return;
            end
            if (is_digit(b))
            begin
                mode     = M_NUM;
                dot_seen = 1'b0;
                add_text(b);
                return;
            end
            if (is_alpha(b) || b == "_")
            begin
                mode   = M_IDENT;
                kw_buf = {40'd0, to_upper(b)};
                add_text(b);
                return;
            end
            if (b == "!")
            begin
                mode = M_BANG;
                return;
            end
            if (b == "<")
            begin
                mode = M_LT;
                return;
            end
            if (b == ">")
            begin
                mode = M_GT;
                return;
            end
            case (b)
                "=":     t = T_EQ;
                "+":     t = T_PLUS;
                "-":     t = T_MINUS;
                "*":     t = T_STAR;
                "/":     t = T_SLASH;
                ".":     t = T_DOT;
                ",":     t = T_COMMA;
                "(":     t = T_LPAREN;
                ")":     t = T_RPAREN;
                ";":     t = T_SEMI;
                default: t = T_INVALID;
            endcase
            push_out(KIND_RECORD, b, t, tok_start, 16'd1);
        endfunction

        function void pair_token(logic [5:0] t);
            push_out(KIND_RECORD, '0, t, tok_start, 16'd2);
            mode = M_IDLE;
        endfunction

        // work out the results of one accepted request
        function void note_request(sts_in_t req);
            logic [7:0] b;
            sts_out_t   r;
            b = req.source_byte;
            step_out.delete();
            if (req.cmd == CMD_END)
            begin
                close_token();
                push_out(KIND_RECORD, '0, T_END, byte_pos, '0);
                clear_state();
            end
            else
            begin
                case (mode)
                    M_STR:
                    begin
                        if (esc_pending)
                        begin
                            esc_pending = 1'b0;
                            add_text(b);
                        end
                        else if (b == (quote_dbl ? CH_DQUOTE : CH_SQUOTE))
                        begin
                            push_out(KIND_RECORD, '0, T_STRING, tok_start, tok_len);
                            mode = M_IDLE;
                        end
                        else if (b == CH_BSLASH)
                            esc_pending = 1'b1;
                        else
                            add_text(b);
                    end
                    M_NUM:
                    begin
                        if (is_digit(b) || (b == "." && !dot_seen))
                        begin
                            if (b == ".")
                                dot_seen = 1'b1;
                            add_text(b);
                        end
                        else
                        begin
                            close_token();
                            open_token(b);
                        end
                    end
                    M_IDENT:
                    begin
                        if (is_word(b))
                        begin
                            if (tok_len < 16'd6)
                                kw_buf = {kw_buf[39:0], to_upper(b)};
                            add_text(b);
                        end
                        else
                        begin
                            close_token();
                            open_token(b);
                        end
                    end
                    M_BANG:
                    begin
                        if (b == "=")
                            pair_token(T_NE);
                        else
                        begin
                            close_token();
                            open_token(b);
                        end
                    end
                    M_LT:
                    begin
                        if (b == ">")
                            pair_token(T_NE);
                        else if (b == "=")
                            pair_token(T_LE);
                        else
                        begin
                            close_token();
                            open_token(b);
                        end
                    end
                    M_GT:
                    begin
                        if (b == "=")
                            pair_token(T_GE);
                        else
                        begin
                            close_token();
                            open_token(b);
                        end
                    end
                    default: open_token(b);
                endcase
                if (byte_pos < POS_CAP)
                    byte_pos++;
            end
            if (step_out.size() > 0)
            begin
                r = step_out.pop_back();
                r.last_of_item = 1'b1;
                step_out.push_back(r);
            end
            foreach (step_out[i])
                expected_tokens.push_back(step_out[i]);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                if (errors < REPORT_CAP)
                    $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sts_out_t got);
            sts_out_t want;
            if (expected_tokens.size() == 0)
            begin
                if (errors < REPORT_CAP)
                    $error("token result with nothing expected: type %0d", got.token_type);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("text_byte", 16'(want.text_byte), 16'(got.text_byte));
            compare_field("token_type", 16'(want.token_type), 16'(got.token_type));
            compare_field("token_pos", want.token_pos, got.token_pos);
            compare_field("text_len", want.text_len, got.text_len);
            compare_field("last_of_item", 16'(want.last_of_item), 16'(got.last_of_item));
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

endpackage

@@ tb/sv/tb_sql_token_scanner.sv @@
// tb_sql_token_scanner: drives source requests into the scanner and checks every token result
// depends on sts_pkg, sts_tb_pkg and the sql_token_scanner rtl
module tb_sql_token_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;
    import sts_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_ITEMS   = 90;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_style_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    sts_in_t  src_item  = '0;
    logic     tok_valid;
    logic     tok_stall = 1'b0;
    sts_out_t tok_item;

    lexer_scoreboard sb;

    int           burst_left  = 0;
    int           sent        = 0;
    int           idle_cycles = 0;
    int           stall_left  = 0;
    stall_style_t stall_style = STALL_NONE;
    logic         stall_next;
    bit           draining    = 1'b0;

    string op_list [17] = '{"!=", "<>", "<=", ">=", "=", "<", ">", "+", "-", "*", "/",
                            ".", ",", "(", ")", ";", "!"};

    sql_token_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                sb.note_request(src_item);
            if (tok_valid && !tok_stall)
                sb.check_result(tok_item);
        end
    end

    // receiver stall pattern, switching style every so often
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_left  = $urandom_range(16, 160);
        end
        else
            stall_left--;
        case (stall_style)
            STALL_NONE:  stall_next = 1'b0;
            STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
            default:     stall_next = ((stall_left % 16) < 9);
        endcase
        tok_stall <= stall_next && !draining;
    end

    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL sql_token_scanner");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input sts_in_t req);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 16);
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        src_item  <= req;
        src_valid <= 1'b1;
        do
            @(posedge clk);
        while (src_stall);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request({CMD_BYTE, b});
    endtask

    task automatic send_end();
        send_request({CMD_END, 8'($urandom)});
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] random_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? 8'(" ") : 8'(8 + k);
    endfunction

    function automatic logic [7:0] random_word_char(input bit lead);
        int k;
        k = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (k < 26)
            return 8'("a" + k);
        if (k < 52)
            return 8'("A" + k - 26);
        if (k == 52)
            return "_";
        return 8'("0" + k - 53);
    endfunction

    // one random lexeme, mostly well formed, with some noise and broken ones
    task automatic send_fragment();
        int         pick;
        int         n;
        logic [7:0] b;
        logic [7:0] q;
        string      s;
        pick = $urandom_range(0, 19);
        if (pick < 4)
        begin
            s = sb.kw_text[$urandom_range(0, NUM_KW - 1)];
            for (int i = 0; i < s.len(); i++)
            begin
                b = s[i];
                if ($urandom_range(0, 1))
                    b = b | 8'h20;
                send_byte(b);
            end
            if ($urandom_range(0, 5) == 0)
                send_byte(random_word_char(1'b0));
        end
        else if (pick < 7)
        begin
            n = $urandom_range(1, 9);
            send_byte(random_word_char(1'b1));
            repeat (n - 1) send_byte(random_word_char(1'b0));
        end
        else if (pick < 10)
        begin
            n = $urandom_range(1, 6);
            send_byte(8'("0" + $urandom_range(0, 9)));
            repeat (n - 1)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_byte(".");
                else
                    send_byte(8'("0" + $urandom_range(0, 9)));
            end
        end
        else if (pick < 13)
        begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            send_byte(q);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                b = 8'($urandom);
                if (b == q || b == CH_BSLASH || $urandom_range(0, 7) == 0)
                    send_byte(CH_BSLASH);
                send_byte(b);
            end
            // leave a few strings open
            if ($urandom_range(0, 9) != 0)
                send_byte(q);
        end
        else if (pick < 17)
            send_text(op_list[$urandom_range(0, 16)]);
        else if (pick == 17)
            send_byte(8'($urandom));
        else if (pick == 18)
            repeat ($urandom_range(1, 3)) send_byte(random_space());
        else if ($urandom_range(0, 3) == 0)
            send_end();
        else
            send_byte(8'($urandom_range(128, 255)));
        if ($urandom_range(0, 2) == 0)
            send_byte(random_space());
    endtask

    task automatic run_directed();
        send_request({CMD_END, 8'hFF});
        send_text("Sel_9 <>!=<= >=!x 1.2.3");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_DQUOTE);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_request({CMD_END, 8'h00});
    endtask

    task automatic run_random();
        int first;
        first = sent;
        while (sent - first < RANDOM_ITEMS)
            send_fragment();
        send_end();
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        src_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        draining = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS sql_token_scanner");
        else
            $display("FAIL sql_token_scanner");
        $finish;
    end

endmodule
